// ===== sv/svc_pkg.sv =====
// Shared types, character codes and helper functions for the semantic version checker.
// This package has no dependencies. The step logic and the top level both use it.
package svc_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  localparam logic [2:0] CORE_PARTS = 3'd3;
  localparam logic [2:0] CORE_SAT   = 3'd7;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

  typedef enum logic [2:0] {
    SEC_CORE  = 3'b001,
    SEC_PRE   = 3'b010,
    SEC_BUILD = 3'b100
  } svc_section_t;

  typedef struct packed {
    svc_section_t section;
    logic [2:0]   core_count;
    logic         ident_nonempty;
    logic         ident_all_digits;
    logic         ident_lead_zero;
    logic         ident_multi;
    logic         failed;
  } svc_state_t;

  localparam svc_state_t STATE_RESET = '{
    section:          SEC_CORE,
    core_count:       3'd0,
    ident_nonempty:   1'b0,
    ident_all_digits: 1'b1,
    ident_lead_zero:  1'b0,
    ident_multi:      1'b0,
    failed:           1'b0
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } svc_in_t;

  typedef struct packed {
    logic version_ok;
    logic too_long;
  } svc_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_digit(c) || ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ||
           ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) || (c == CHAR_MINUS);
  endfunction

  function automatic logic ident_ok(input svc_state_t s, input logic check_zero);
    return s.ident_nonempty &&
           !(check_zero && s.ident_all_digits && s.ident_lead_zero && s.ident_multi);
  endfunction

endpackage

// ===== sv/svc_step.sv =====
// Per-character rule logic for the semantic version checker: next parse state and verdict.
// Depends on svc_pkg for the state type, character codes and identifier helpers.
module svc_step (
  input  svc_pkg::svc_state_t state,
  input  logic [7:0]          char_code,
  output svc_pkg::svc_state_t state_next,
  output logic                rules_ok
);

  svc_pkg::svc_state_t s;
  logic                fin;

  always_comb begin
    s = state;
    if (!state.failed) begin
      unique case (state.section)
        svc_pkg::SEC_CORE: begin
          if (svc_pkg::is_digit(char_code)) begin
            if (!s.ident_nonempty) s.ident_lead_zero = (char_code == svc_pkg::CHAR_ZERO);
            else s.ident_multi = 1'b1;
            s.ident_nonempty = 1'b1;
          end else if (char_code == svc_pkg::CHAR_DOT) begin
            if (!svc_pkg::ident_ok(s, 1'b1)) s.failed = 1'b1;
            s.ident_nonempty   = 1'b0;
            s.ident_all_digits = 1'b1;
            s.ident_lead_zero  = 1'b0;
            s.ident_multi      = 1'b0;
            if (s.core_count < svc_pkg::CORE_SAT) s.core_count = s.core_count + 3'd1;
          end else if (char_code == svc_pkg::CHAR_MINUS || char_code == svc_pkg::CHAR_PLUS) begin
            if (!svc_pkg::ident_ok(s, 1'b1) ||
                (s.core_count != svc_pkg::CORE_PARTS - 3'd1)) s.failed = 1'b1;
            s.ident_nonempty   = 1'b0;
            s.ident_all_digits = 1'b1;
            s.ident_lead_zero  = 1'b0;
            s.ident_multi      = 1'b0;
            s.section = (char_code == svc_pkg::CHAR_MINUS) ? svc_pkg::SEC_PRE
                                                           : svc_pkg::SEC_BUILD;
          end else begin
            s.failed = 1'b1;
          end
        end
        svc_pkg::SEC_PRE, svc_pkg::SEC_BUILD: begin
          if (char_code == svc_pkg::CHAR_DOT ||
              (char_code == svc_pkg::CHAR_PLUS && state.section == svc_pkg::SEC_PRE)) begin
            if (!svc_pkg::ident_ok(s, state.section == svc_pkg::SEC_PRE)) s.failed = 1'b1;
            s.ident_nonempty   = 1'b0;
            s.ident_all_digits = 1'b1;
            s.ident_lead_zero  = 1'b0;
            s.ident_multi      = 1'b0;
            if (char_code == svc_pkg::CHAR_PLUS) s.section = svc_pkg::SEC_BUILD;
          end else if (svc_pkg::is_ident_char(char_code)) begin
            if (!s.ident_nonempty) s.ident_lead_zero = (char_code == svc_pkg::CHAR_ZERO);
            else s.ident_multi = 1'b1;
            s.ident_nonempty = 1'b1;
            if (!svc_pkg::is_digit(char_code)) s.ident_all_digits = 1'b0;
          end else begin
            s.failed = 1'b1;
          end
        end
        default: s.failed = 1'b1;
      endcase
    end
  end

  always_comb begin
    unique case (s.section)
      svc_pkg::SEC_CORE:  fin = svc_pkg::ident_ok(s, 1'b1) &&
                                (s.core_count == svc_pkg::CORE_PARTS - 3'd1);
      svc_pkg::SEC_PRE:   fin = svc_pkg::ident_ok(s, 1'b1);
      svc_pkg::SEC_BUILD: fin = svc_pkg::ident_ok(s, 1'b0);
      default:            fin = 1'b0;
    endcase
  end

  assign state_next = s;
  assign rules_ok   = !s.failed && fin;

endmodule

// ===== sv/semver_string_checker.sv =====
// Top level of the semantic version checker: request register, parse state, result register.
// Depends on svc_pkg and svc_step.
//
// The block takes one character request per cycle and gives one result on the last character
// of each string: version_ok when the string is a valid semantic version no longer than
// max_length, too_long when the saturating character count exceeds max_length. A character
// waits in the request register until it is consumed, is then folded into the parse state,
// and its result (if it is the last one) is loaded into the result register when it is
// consumed, so a result is offered once its last character is consumed. Throughput is one character
// per cycle; a result left waiting stalls only the next last character. max_length resets to
// 64 and may be written whenever no string is in flight.
module semver_string_checker #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  svc_pkg::svc_in_t    char_data,
  output logic                result_valid,
  input  logic                result_ready,
  output svc_pkg::svc_out_t   result_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  logic                   hold_valid;
  svc_pkg::svc_in_t       hold;
  logic [7:0]             max_length;
  svc_pkg::svc_state_t    state;
  svc_pkg::svc_state_t    state_next;
  logic [COUNT_WIDTH-1:0] char_count;
  logic [COUNT_WIDTH-1:0] char_count_next;
  logic                   rules_ok;
  logic                   too_long_next;
  logic                   consume;

  svc_step u_step (
    .state      (state),
    .char_code  (hold.char_code),
    .state_next (state_next),
    .rules_ok   (rules_ok)
  );

  assign char_count_next = (char_count == {COUNT_WIDTH{1'b1}}) ? char_count
                                                               : char_count + 1'b1;
  assign too_long_next   = CMP_WIDTH'(char_count_next) > CMP_WIDTH'(max_length);
  assign consume    = hold_valid && (!hold.last_char || !result_valid || result_ready);
  assign char_ready = !hold_valid || consume;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= svc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_ready) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      hold <= char_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= svc_pkg::STATE_RESET;
      char_count <= '0;
    end else if (consume) begin
      if (hold.last_char) begin
        state      <= svc_pkg::STATE_RESET;
        char_count <= '0;
      end else begin
        state      <= state_next;
        char_count <= char_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && hold.last_char) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && hold.last_char) begin
      result_data.version_ok <= rules_ok && !too_long_next;
      result_data.too_long   <= too_long_next;
    end
  end

  a_ok_within_length: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_data.version_ok && result_data.too_long))
    else $error("version_ok raised together with too_long");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (consume && hold.last_char) |=> (state == svc_pkg::STATE_RESET && char_count == '0))
    else $error("parse state not cleared after last character");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !char_ready |-> (hold_valid && hold.last_char && result_valid && !result_ready))
    else $error("request stalled without a blocked last character");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (consume && hold.last_char) |=> result_valid)
    else $error("last character consumed without a result");

endmodule
